// ===== hw/rtl/pftq_pkg.sv =====
// Package: shared types, constants and pointer helpers of the PDU framer transmit queue.
`timescale 1ns / 1ps

package pftq_pkg;

    localparam int QUEUE_WORDS  = 256;
    localparam int ADDR_W       = $clog2(QUEUE_WORDS);
    localparam int WORD_W       = 16;
    localparam int SPACE_MARGIN = 4;
    localparam int SPACE_W      = ((ADDR_W > 9) ? ADDR_W : 9) + 1;
    localparam int WB_DEPTH     = 3;

    localparam logic [7:0]  XOFF_RESET   = 8'd160;
    localparam logic [7:0]  OPC_SEQ_MASK = 8'h1E;
    localparam logic [7:0]  OPC_PROTO    = 8'h10;
    localparam logic [7:0]  CK_MINUS_ONE = 8'hFF;
    localparam logic [15:0] LEN_FLAG     = 16'h8000;

    typedef logic [ADDR_W-1:0] t_ptr;
    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [1:0] {
        KIND_PUSH   = 2'd0,
        KIND_POP    = 2'd1,
        KIND_RESUME = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        CFG_QUEUE_DISABLED = 2'd0,
        CFG_TWO_OCTET      = 2'd1,
        CFG_XOFF_LEVEL     = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic        pop_valid;
        logic [15:0] drop_total;
        logic        xon_status;
        logic        host_notify;
        logic        pdu_rejected;
        logic        byte_taken;
    } t_result;

    function automatic t_ptr ptr_inc(input t_ptr p);
        if (p == t_ptr'(QUEUE_WORDS - 1)) begin
            return '0;
        end
        return p + t_ptr'(1);
    endfunction

    function automatic t_ptr ptr_used(input t_ptr w, input t_ptr r);
        if (w >= r) begin
            return w - r;
        end
        return t_ptr'(QUEUE_WORDS + int'(w) - int'(r));
    endfunction

endpackage

// ===== hw/rtl/pftq_ram.sv =====
// Ring word store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module pftq_ram (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  pftq_pkg::t_ptr        i_waddr,
    input  pftq_pkg::t_word       i_wdata,
    input  logic                  i_re,
    input  pftq_pkg::t_ptr        i_raddr,
    output pftq_pkg::t_word       o_rdata
);
    import pftq_pkg::*;

    t_word r_mem [QUEUE_WORDS];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/pdu_framer_tx_queue_top.sv =====
// Top level: PDU framer writing framed words into the transmit ring, with pop and XON control.
// A result is registered and presented in the cycle after its item is accepted.
// Throughput: one item per cycle unless the output stalls, or one per queue word written when a
//   push writes more (up to three words), paced by the single write port of the ring store.
// A new item is taken while at most one word of the previous one is still to be written.
// Reset (synchronous, active low) clears pointers, counters, flags and config registers;
//   ring contents are undefined until written, with no clearing pass.
`timescale 1ns / 1ps

module pdu_framer_tx_queue_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // pdu_byte[7:0], pdu_len[17:8], zero pad
    input  logic [2:0]  s_axis_tuser,   // kind[1:0], first_of_pdu[2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // byte_taken[0], pdu_rejected[1], host_notify[2],
                                        // xon_status[3], drop_total[19:4], pop_word[35:20],
                                        // pop_valid[36], zero pad
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata
);
    import pftq_pkg::*;

    // config
    logic       r_disabled;
    logic       r_two_octet;
    logic [7:0] r_xoff_level;

    // framing state
    t_ptr        r_wptr, n_wptr;
    t_ptr        r_rptr, n_rptr;
    logic [2:0]  r_seq, n_seq;
    logic        r_xon, n_xon;
    logic [15:0] r_drop, n_drop;
    logic [9:0]  r_bidx, n_bidx;
    logic [9:0]  r_flen, n_flen;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_hbyte, n_hbyte;
    logic        r_hvalid, n_hvalid;
    logic        r_disc, n_disc;

    // pending writes
    t_word       r_wb_word [WB_DEPTH];
    t_ptr        r_wb_addr;
    logic [1:0]  r_wb_cnt;
    t_word       nw [WB_DEPTH];
    logic [1:0]  nk;

    // result
    logic        r_out_valid;
    t_result     r_res, n_res;
    logic        r_fwd;
    t_word       r_fwd_word;
    t_word       ram_rdata;
    logic        rd_en;

    logic        fire;
    t_kind       kind;
    logic [7:0]  in_byte;
    logic [9:0]  in_len, len_eff;
    logic        in_first;
    t_ptr        used;
    logic [SPACE_W-1:0] space_need;
    logic [7:0]  opc, hi, lo, s0, s1;
    logic [10:0] nlen;
    logic [9:0]  bidx1;
    t_ptr        p1, p2, p3;

    assign kind     = t_kind'(s_axis_tuser[1:0]);
    assign in_first = s_axis_tuser[2];
    assign in_byte  = s_axis_tdata[7:0];
    assign in_len   = s_axis_tdata[17:8];
    assign len_eff  = (in_len == 10'd0) ? 10'd1 : in_len;

    assign s_axis_tready = (!r_out_valid || m_axis_tready) && (r_wb_cnt <= 2'd1);
    assign fire          = s_axis_tvalid && s_axis_tready;

    assign used       = ptr_used(r_wptr, r_rptr);
    assign space_need = SPACE_W'(used) + SPACE_W'(len_eff[9:1]);
    assign p1         = ptr_inc(r_wptr);
    assign p2         = ptr_inc(p1);
    assign p3         = ptr_inc(p2);

    always_comb begin
        n_rptr   = r_rptr;
        n_seq    = r_seq;
        n_xon    = r_xon;
        n_drop   = r_drop;
        n_bidx   = r_bidx;
        n_flen   = r_flen;
        n_sum    = r_sum;
        n_hbyte  = r_hbyte;
        n_hvalid = r_hvalid;
        n_disc   = r_disc;
        n_res    = '0;
        rd_en    = 1'b0;
        nk       = 2'd0;
        for (int i = 0; i < WB_DEPTH; i++) begin
            nw[i] = '0;
        end
        opc   = (in_byte & ~OPC_SEQ_MASK) | {4'd0, r_seq, 1'b0} | (r_two_octet ? OPC_PROTO : 8'h00);
        nlen  = 11'(len_eff) + (r_two_octet ? 11'd3 : 11'd2);
        hi    = 8'((16'(nlen) | LEN_FLAG) >> 8);
        lo    = nlen[7:0];
        s0    = r_two_octet ? (hi + lo) : lo;
        s1    = s0 + opc;
        bidx1 = r_bidx + 10'd1;

        if (fire) begin
            unique case (kind)
                KIND_PUSH: begin
                    if (in_first) begin
                        n_bidx   = '0;
                        n_flen   = '0;
                        n_hvalid = 1'b0;
                        n_disc   = 1'b0;
                        if (r_disabled) begin
                            n_res.host_notify  = 1'b1;
                            n_res.pdu_rejected = 1'b1;
                            n_disc             = 1'b1;
                        end else begin
                            if (r_xon && (SPACE_W'(used) > SPACE_W'(r_xoff_level))) begin
                                n_xon             = 1'b0;
                                n_res.host_notify = 1'b1;
                            end
                            if (space_need >= SPACE_W'(QUEUE_WORDS - SPACE_MARGIN)) begin
                                n_drop             = r_drop + 16'd1;
                                n_res.host_notify  = 1'b1;
                                n_res.pdu_rejected = 1'b1;
                                n_disc             = 1'b1;
                            end else begin
                                n_seq            = r_seq + 3'd1;
                                n_flen           = len_eff;
                                n_res.byte_taken = 1'b1;
                                n_bidx           = 10'd1;
                                n_sum            = s1;
                                nw[0]            = t_word'(nlen);
                                if (r_two_octet) begin
                                    nw[1] = {lo, hi};
                                    if (len_eff == 10'd1) begin
                                        nw[2] = {s1 + CK_MINUS_ONE, opc};
                                        nk    = 2'd3;
                                    end else begin
                                        n_hbyte  = opc;
                                        n_hvalid = 1'b1;
                                        nk       = 2'd2;
                                    end
                                end else begin
                                    // upper length bits overlay the opcode octet
                                    nw[1] = {opc, 8'h00} | t_word'(nlen);
                                    if (len_eff == 10'd1) begin
                                        nw[2] = {8'h00, s1 + CK_MINUS_ONE};
                                        nk    = 2'd3;
                                    end else begin
                                        nk = 2'd2;
                                    end
                                end
                            end
                        end
                    end else if (!r_disc && (r_bidx < r_flen)) begin
                        n_res.byte_taken = 1'b1;
                        n_sum            = r_sum + in_byte;
                        n_bidx           = bidx1;
                        if (r_hvalid) begin
                            nw[0]    = {in_byte, r_hbyte};
                            n_hvalid = 1'b0;
                            if (bidx1 == r_flen) begin
                                nw[1] = {8'h00, n_sum + CK_MINUS_ONE};
                                nk    = 2'd2;
                            end else begin
                                nk = 2'd1;
                            end
                        end else if (bidx1 == r_flen) begin
                            nw[0]    = {n_sum + CK_MINUS_ONE, in_byte};
                            nk       = 2'd1;
                            n_hvalid = 1'b0;
                        end else begin
                            n_hbyte  = in_byte;
                            n_hvalid = 1'b1;
                        end
                    end
                end
                KIND_POP: begin
                    if (r_rptr != r_wptr) begin
                        n_res.pop_valid = 1'b1;
                        n_rptr          = ptr_inc(r_rptr);
                        rd_en           = 1'b1;
                    end
                end
                KIND_RESUME: begin
                    n_xon = 1'b1;
                end
                default: begin
                end
            endcase
        end
        n_res.xon_status = n_xon;
        n_res.drop_total = n_drop;
    end

    always_comb begin
        unique case (nk)
            2'd0:    n_wptr = r_wptr;
            2'd1:    n_wptr = p1;
            2'd2:    n_wptr = p2;
            default: n_wptr = p3;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disabled   <= 1'b0;
            r_two_octet  <= 1'b0;
            r_xoff_level <= XOFF_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_QUEUE_DISABLED: r_disabled   <= i_cfg_wdata[0];
                CFG_TWO_OCTET:      r_two_octet  <= i_cfg_wdata[0];
                CFG_XOFF_LEVEL:     r_xoff_level <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_seq       <= '0;
            r_xon       <= 1'b1;
            r_drop      <= '0;
            r_bidx      <= '0;
            r_flen      <= '0;
            r_sum       <= '0;
            r_hbyte     <= '0;
            r_hvalid    <= 1'b0;
            r_disc      <= 1'b0;
            r_wb_cnt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_wptr   <= n_wptr;
            r_rptr   <= n_rptr;
            r_seq    <= n_seq;
            r_xon    <= n_xon;
            r_drop   <= n_drop;
            r_bidx   <= n_bidx;
            r_flen   <= n_flen;
            r_sum    <= n_sum;
            r_hbyte  <= n_hbyte;
            r_hvalid <= n_hvalid;
            r_disc   <= n_disc;
            if (fire && (nk != 2'd0)) begin
                r_wb_cnt <= nk;
            end else if (r_wb_cnt != 2'd0) begin
                r_wb_cnt <= r_wb_cnt - 2'd1;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // pending word buffer: load on a push, else shift one word out per cycle
    always_ff @(posedge i_clk) begin
        if (fire && (nk != 2'd0)) begin
            r_wb_addr <= r_wptr;
            for (int i = 0; i < WB_DEPTH; i++) begin
                r_wb_word[i] <= nw[i];
            end
        end else if (r_wb_cnt != 2'd0) begin
            r_wb_addr <= ptr_inc(r_wb_addr);
            for (int i = 0; i < WB_DEPTH - 1; i++) begin
                r_wb_word[i] <= r_wb_word[i+1];
            end
            r_wb_word[WB_DEPTH-1] <= '0;
        end
    end

    // result register; a pop hitting the word being written this cycle is forwarded
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res      <= n_res;
            r_fwd      <= rd_en && (r_wb_cnt != 2'd0) && (r_wb_addr == r_rptr);
            r_fwd_word <= r_wb_word[0];
        end
    end

    pftq_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (r_wb_cnt != 2'd0),
        .i_waddr (r_wb_addr),
        .i_wdata (r_wb_word[0]),
        .i_re    (rd_en),
        .i_raddr (r_rptr),
        .o_rdata (ram_rdata)
    );

    t_word pop_word;
    assign pop_word = !r_res.pop_valid ? '0 : (r_fwd ? r_fwd_word : ram_rdata);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_res.pop_valid, pop_word, r_res.drop_total,
                            r_res.xon_status, r_res.host_notify, r_res.pdu_rejected,
                            r_res.byte_taken};

    a_held_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hvalid |-> (!r_disc && (r_bidx < r_flen)))
        else $error("held octet outside an open frame");

    a_disc_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_disc |-> ((r_flen == 10'd0) && (r_bidx == 10'd0)))
        else $error("discarding with a frame still open");

    a_pop_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.pop_valid) |-> (!r_res.byte_taken && !r_res.pdu_rejected))
        else $error("pop result carries push flags");

    a_wb_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (r_wb_cnt <= 2'd3) && ($past(nk) == 2'd0 || r_wb_cnt == $past(nk)))
        else $error("pending word count lost");

endmodule
